[rtl/sbds_pkg.sv]
`default_nettype none

package sbds_pkg;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_PROTO = 2'd1;
	localparam logic [1:0] ST_CHAN  = 2'd2;

	// control and format word pieces
	localparam logic [17:0] CTRL_BASE     = 18'h10000;
	localparam logic [17:0] CTRL_IDLE_BIT = 18'h20000;
	localparam logic [27:0] FMT_BASE      = 28'h8000000;
	localparam logic [27:0] FMT_PHASE_BIT = 28'h0010000;

	// module clock after reset
	localparam logic [31:0] CLK_RESET = 32'd80000000;

	// quotient width of clk/2 over n, one bit per divider step
	localparam int        QUO_W    = 31;
	localparam logic [4:0] DIV_LAST = 5'(QUO_W - 1);

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic absd;
		logic cmp;
		logic next;
		logic publish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic err;
		logic div_last;
		logic improve;
		logic n_last;
	} dp_sts_t;

endpackage

`default_nettype wire

[rtl/spi_baud_divider_search.sv]
`default_nettype none

// spi serial clock divider search
//
// a request (baud_rate, channel, mode) is taken at a clock edge with start high
// and busy low. busy stays high while the request is worked on. the result
// (status, divisor, control_word, format_word, chip_select_used) appears for
// exactly one cycle with done high; the ports hold their value until the next
// result, and the receiver cannot stall. a new request may be started in the
// done cycle itself.
// sequence: a rejected request (bad mode or bad channel) passes the check and
// publish states before done. otherwise every candidate divisor takes 31 steps
// of the one-bit-per-cycle restoring divider for (clock/2)/n, then the
// absolute difference and then the compare, with up to DIVISOR_MAX divisors.
// the module clock register is written through cfg_valid/cfg_ready, always
// ready. the user must write it only while the block is idle; the block itself
// does not enforce this. reset loads 80 MHz into it and returns the controller
// to idle with done low.
module spi_baud_divider_search #(
	parameter int DIVISOR_MAX = 4095
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request item
	input  wire logic        start,
	output logic             busy,
	input  wire logic [30:0] baud_rate,
	input  wire logic [3:0]  channel,
	input  wire logic [6:0]  mode,
	// configuration write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] module_clock_hz,
	// result item
	output logic             done,
	output logic [1:0]       status,
	output logic [11:0]      divisor,
	output logic [17:0]      control_word,
	output logic [27:0]      format_word,
	output logic             chip_select_used
);

	sbds_pkg::dp_cmd_t cmd;
	sbds_pkg::dp_sts_t sts;

	// register write never waits
	assign cfg_ready = 1'b1;

	// sequencer: check, then divide / difference / compare per candidate
	sbds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	// divider, best-so-far tracking and result registers
	sbds_dp #(
		.DIVISOR_MAX (DIVISOR_MAX)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_data         (module_clock_hz),
		.baud_rate        (baud_rate),
		.channel          (channel),
		.mode             (mode),
		.cmd              (cmd),
		.sts              (sts),
		.status           (status),
		.divisor          (divisor),
		.control_word     (control_word),
		.format_word      (format_word),
		.chip_select_used (chip_select_used)
	);

	// a result strobe is a single cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// an accepted item keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// status code is one of the three defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == sbds_pkg::ST_OK || status == sbds_pkg::ST_PROTO ||
			status == sbds_pkg::ST_CHAN))
		else $error("undefined status code");

	// rejected items carry the fixed default fields
	a_err_defaults: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != sbds_pkg::ST_OK) |->
			(divisor == 12'd1 && control_word == sbds_pkg::CTRL_BASE &&
			format_word == sbds_pkg::FMT_BASE && !chip_select_used))
		else $error("rejected item with non-default fields");

endmodule

`default_nettype wire

[rtl/sbds_ctrl.sv]
`default_nettype none

module sbds_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	output logic                  done,
	output sbds_pkg::dp_cmd_t     cmd,
	input  wire sbds_pkg::dp_sts_t sts
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_ABS   = 3'd3;
	localparam logic [2:0] S_CMP   = 3'd4;
	localparam logic [2:0] S_PUB   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = sts.err ? S_PUB : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_ABS;
				end
			end
			S_ABS: begin
				cmd.absd = 1'b1;
				state_d  = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				if (sts.improve && !sts.n_last) begin
					cmd.next = 1'b1;
					state_d  = S_DIV;
				end else begin
					state_d = S_PUB;
				end
			end
			S_PUB: begin
				cmd.publish = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_PUB);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_done_after_pub: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_PUB))
		else $error("done without publish");

	a_err_skips_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && sts.err) |=> state_q == S_PUB)
		else $error("error item entered search");

	a_div_runs_from_check_or_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && $past(state_q) != S_DIV) |->
			($past(state_q) == S_CHECK || $past(state_q) == S_CMP))
		else $error("divide entered from wrong state");

endmodule

`default_nettype wire

[rtl/sbds_dp.sv]
`default_nettype none

module sbds_dp #(
	parameter int DIVISOR_MAX = 4095
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_data,
	input  wire logic [30:0]       baud_rate,
	input  wire logic [3:0]        channel,
	input  wire logic [6:0]        mode,
	input  wire sbds_pkg::dp_cmd_t cmd,
	output sbds_pkg::dp_sts_t      sts,
	output logic [1:0]             status,
	output logic [11:0]            divisor,
	output logic [17:0]            control_word,
	output logic [27:0]            format_word,
	output logic                   chip_select_used
);

	localparam int NW = $clog2(DIVISOR_MAX + 1);

	logic [31:0]   clk_hz_q;
	logic [30:0]   baud_q;
	logic [1:0]    cmode_q;
	logic          cs_q;
	logic [1:0]    st_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] best_q;
	logic [31:0]   best_diff_q;
	logic [30:0]   d_q;
	logic [NW-1:0] rem_q;
	logic [30:0]   quo_q;
	logic [4:0]    cnt_q;

	logic [1:0]    st_in;
	logic [NW:0]   trial;
	logic [NW:0]   trial_sub;
	logic          ge;
	logic [30:0]   d_next;
	logic          improve;

	always_comb begin
		if (mode[6] || mode[4] || mode[2]) begin
			st_in = sbds_pkg::ST_PROTO;
		end else if (channel == 4'd1 || channel == 4'd2 || channel == 4'd4) begin
			st_in = sbds_pkg::ST_OK;
		end else begin
			st_in = sbds_pkg::ST_CHAN;
		end
	end

	// one restoring divider step
	assign trial     = {rem_q, quo_q[30]};
	assign trial_sub = trial - {1'b0, n_q};
	assign ge        = (trial >= {1'b0, n_q});

	assign d_next  = (baud_q >= quo_q) ? (baud_q - quo_q) : (quo_q - baud_q);
	assign improve = ({1'b0, d_q} < best_diff_q);

	assign sts.err      = (st_q != sbds_pkg::ST_OK);
	assign sts.div_last = (cnt_q == sbds_pkg::DIV_LAST);
	assign sts.improve  = improve;
	assign sts.n_last   = (n_q == NW'(DIVISOR_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= sbds_pkg::CLK_RESET;
		end else if (cfg_we) begin
			clk_hz_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			baud_q      <= baud_rate;
			cmode_q     <= mode[1:0];
			cs_q        <= mode[5];
			st_q        <= st_in;
			n_q         <= NW'(1);
			best_q      <= NW'(1);
			best_diff_q <= clk_hz_q;
		end
		if (cmd.load || cmd.next) begin
			rem_q <= '0;
			quo_q <= clk_hz_q[31:1];
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[NW-1:0] : trial[NW-1:0];
			quo_q <= {quo_q[29:0], ge};
			cnt_q <= cnt_q + 5'd1;
		end
		if (cmd.absd) begin
			d_q <= d_next;
		end
		if (cmd.cmp && improve) begin
			best_q      <= n_q;
			best_diff_q <= {1'b0, d_q};
		end
		if (cmd.next) begin
			n_q <= n_q + NW'(1);
		end
		if (cmd.publish) begin
			status <= st_q;
			if (st_q != sbds_pkg::ST_OK) begin
				divisor          <= 12'd1;
				control_word     <= sbds_pkg::CTRL_BASE;
				format_word      <= sbds_pkg::FMT_BASE;
				chip_select_used <= 1'b0;
			end else begin
				divisor          <= 12'(best_q);
				control_word     <= sbds_pkg::CTRL_BASE |
					((cmode_q == 2'd0 || cmode_q == 2'd1) ? sbds_pkg::CTRL_IDLE_BIT : '0);
				format_word      <= sbds_pkg::FMT_BASE |
					(cmode_q[0] ? sbds_pkg::FMT_PHASE_BIT : '0);
				chip_select_used <= cs_q;
			end
		end
	end

endmodule

`default_nettype wire

[verif/spi_baud_divider_search_test.sv]
`default_nettype none

// testbench for the spi serial clock divider search
//
// requests go in over start/busy, one result comes back per request on done.
// a short table of hand-picked requests runs first: correct rates that hit a
// divisor exactly, a tie between two divisors, no divisor improving at all,
// the full 4095-divisor search, every bad mode bit, bad channels, and the
// smallest and largest module clock. rows whose answer is obvious carry it
// typed in; the rest go through the local divider search predictor.
// after that, random requests run under four module clock settings. most of
// them are legal setups aimed near a chosen divisor so the search goes past
// the first candidates, the rest are raw noise that mostly hits the mode and
// channel checks. the sender works in bursts with gaps of varying length,
// and now and then waits until every pending result is back.
module spi_baud_divider_search_test;

	// codes and word pieces shared with the design
	localparam logic [1:0]  ST_OK         = sbds_pkg::ST_OK;
	localparam logic [1:0]  ST_PROTO      = sbds_pkg::ST_PROTO;
	localparam logic [1:0]  ST_CHAN       = sbds_pkg::ST_CHAN;
	localparam logic [17:0] CTRL_BASE     = sbds_pkg::CTRL_BASE;
	localparam logic [17:0] CTRL_IDLE_BIT = sbds_pkg::CTRL_IDLE_BIT;
	localparam logic [27:0] FMT_BASE      = sbds_pkg::FMT_BASE;
	localparam logic [27:0] FMT_PHASE_BIT = sbds_pkg::FMT_PHASE_BIT;
	localparam logic [31:0] CLK_RESET     = sbds_pkg::CLK_RESET;

	localparam int DIVISOR_LIMIT = 4095;
	// longest correct wait: a full 4095-divisor search, plus a sender gap
	localparam int STALL_LIMIT   = 400000;
	localparam int ITEMS_PER_CLK = 20;
	localparam int REPORT_LIMIT  = 10;

	// mode byte fields
	localparam logic [6:0] MODE_WIDE    = 7'h04;
	localparam logic [6:0] MODE_IGNORED = 7'h08;
	localparam logic [6:0] MODE_SLAVE   = 7'h10;
	localparam logic [6:0] MODE_CS      = 7'h20;
	localparam logic [6:0] MODE_LINE    = 7'h40;
	localparam logic [6:0] MODE_REJECT  = MODE_WIDE | MODE_SLAVE | MODE_LINE;
	localparam int         MODE_CS_BIT  = 5;

	// the only channels that pass the channel check
	localparam logic [3:0] CHAN_ONE  = 4'd1;
	localparam logic [3:0] CHAN_TWO  = 4'd2;
	localparam logic [3:0] CHAN_FOUR = 4'd4;

	localparam logic [17:0] CTRL_IDLE_HI = CTRL_BASE | CTRL_IDLE_BIT;
	localparam logic [27:0] FMT_PHASED   = FMT_BASE | FMT_PHASE_BIT;
	localparam logic [30:0] BAUD_MAX     = '1;
	localparam logic [31:0] CLK_MAX      = '1;

	typedef enum logic [1:0] {
		SCK_MODE0,
		SCK_MODE1,
		SCK_MODE2,
		SCK_MODE3
	} sck_mode_t;

	typedef struct {
		logic [30:0] baud;
		logic [3:0]  chan;
		logic [6:0]  mode;
	} setup_req_t;

	typedef struct {
		logic [1:0]  status;
		logic [11:0] divisor;
		logic [17:0] ctrl;
		logic [27:0] fmt;
		logic        cs;
	} setup_res_t;

	// one row of the directed table; typed rows carry their answer
	typedef struct {
		logic [31:0] hz;
		setup_req_t  req;
		bit          typed;
		setup_res_t  res;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [30:0] baud_rate;
	logic [3:0]  channel;
	logic [6:0]  mode;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] module_clock_hz;
	logic        done;
	logic [1:0]  status;
	logic [11:0] divisor;
	logic [17:0] control_word;
	logic [27:0] format_word;
	logic        chip_select_used;

	setup_res_t  pending_setups[$];
	plan_row_t   plan[$];
	setup_res_t  oldest;
	setup_res_t  blank_res;
	logic [31:0] clock_now;
	logic [31:0] phase_hz;
	int          fault_count = 0;
	int          idle_cycles = 0;
	int          results_seen = 0;
	int          items_left;
	int          burst;

	spi_baud_divider_search #(
		.DIVISOR_MAX(DIVISOR_LIMIT)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.baud_rate        (baud_rate),
		.channel          (channel),
		.mode             (mode),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.module_clock_hz  (module_clock_hz),
		.done             (done),
		.status           (status),
		.divisor          (divisor),
		.control_word     (control_word),
		.format_word      (format_word),
		.chip_select_used (chip_select_used)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// expected result of one setup request under module clock hz
	function automatic setup_res_t predict_setup(setup_req_t q, logic [31:0] hz);
		setup_res_t      r;
		sck_mode_t       sck;
		longint unsigned hz64;
		longint unsigned baud64;
		longint unsigned best_gap;
		longint unsigned tone;
		longint unsigned gap;
		int              best_n;
		r.status  = ST_OK;
		r.divisor = 12'd1;
		r.ctrl    = CTRL_BASE;
		r.fmt     = FMT_BASE;
		r.cs      = 1'b0;
		// mode check wins over the channel check
		if ((q.mode & MODE_REJECT) != '0) begin
			r.status = ST_PROTO;
			return r;
		end
		if (q.chan != CHAN_ONE && q.chan != CHAN_TWO && q.chan != CHAN_FOUR) begin
			r.status = ST_CHAN;
			return r;
		end
		sck = sck_mode_t'(q.mode[1:0]);
		if (sck == SCK_MODE0 || sck == SCK_MODE1) begin
			r.ctrl = CTRL_IDLE_HI;
		end
		if (sck == SCK_MODE1 || sck == SCK_MODE3) begin
			r.fmt = FMT_PHASED;
		end
		r.cs = q.mode[MODE_CS_BIT];
		// walk divisors up while the serial clock strictly closes in on the rate;
		// the first gap no smaller than the best one ends it, ties keep the lower n
		hz64     = hz;
		baud64   = q.baud;
		best_gap = hz64;
		best_n   = 1;
		for (int n = 1; n <= DIVISOR_LIMIT; n++) begin
			tone = hz64 / (2 * longint'(n));
			gap  = (baud64 >= tone) ? baud64 - tone : tone - baud64;
			if (gap < best_gap) begin
				best_gap = gap;
				best_n   = n;
			end else begin
				break;
			end
		end
		r.divisor = 12'(best_n);
		return r;
	endfunction

	// random request; mostly legal and aimed near a chosen divisor
	function automatic setup_req_t random_setup(logic [31:0] hz);
		setup_req_t      q;
		longint unsigned base;
		longint unsigned spread;
		longint unsigned pick;
		int              aim;
		if ($urandom_range(0, 4) == 0) begin
			// raw noise, mostly rejected by the mode or channel check
			q.baud = 31'($urandom);
			q.chan = 4'($urandom_range(0, 15));
			q.mode = 7'($urandom_range(0, 127));
			return q;
		end
		case ($urandom_range(0, 2))
			0: q.chan = CHAN_ONE;
			1: q.chan = CHAN_TWO;
			default: q.chan = CHAN_FOUR;
		endcase
		q.mode = 7'($urandom_range(0, 127)) & ~MODE_REJECT;
		// an occasional deep search, most stay short to keep the run fast
		aim    = ($urandom_range(0, 24) == 0) ? $urandom_range(41, 1500) : $urandom_range(1, 40);
		base   = longint'(hz) / (2 * longint'(aim));
		spread = base / (2 * longint'(aim)) + 1;
		pick   = $urandom_range(0, 32'(spread));
		if ($urandom_range(0, 1) == 1) begin
			pick = base + pick;
		end else begin
			pick = (pick > base) ? 0 : base - pick;
		end
		if (pick > BAUD_MAX) begin
			pick = BAUD_MAX;
		end
		q.baud = 31'(pick);
		return q;
	endfunction

	task automatic add_fixed(logic [31:0] hz, logic [30:0] baud, logic [3:0] chan,
		logic [6:0] md, logic [1:0] st, logic [11:0] dv, logic [17:0] ctrl,
		logic [27:0] fmt, logic cs);
		plan_row_t row;
		row.hz          = hz;
		row.req.baud    = baud;
		row.req.chan    = chan;
		row.req.mode    = md;
		row.typed       = 1'b1;
		row.res.status  = st;
		row.res.divisor = dv;
		row.res.ctrl    = ctrl;
		row.res.fmt     = fmt;
		row.res.cs      = cs;
		plan.push_back(row);
	endtask

	task automatic add_open(logic [31:0] hz, logic [30:0] baud, logic [3:0] chan,
		logic [6:0] md);
		plan_row_t row;
		row.hz       = hz;
		row.req.baud = baud;
		row.req.chan = chan;
		row.req.mode = md;
		row.typed    = 1'b0;
		row.res      = blank_res;
		plan.push_back(row);
	endtask

	task automatic flag(string msg);
		if (fault_count < REPORT_LIMIT) begin
			$display("mismatch at result %0d: %s", results_seen, msg);
		end
		fault_count++;
	endtask

	// present one request and hold it until the block takes it
	task automatic send_setup(setup_req_t q, bit typed, setup_res_t fixed);
		@(negedge clk);
		start     = 1'b1;
		baud_rate = q.baud;
		channel   = q.chan;
		mode      = q.mode;
		do @(posedge clk); while (busy);
		pending_setups.push_back(typed ? fixed : predict_setup(q, clock_now));
	endtask

	task automatic hold_off(int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// stop sending until every pending result is back and the block is idle
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_setups.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// module clock writes only happen with the block idle
	task automatic program_clock(logic [31:0] hz);
		drain();
		@(negedge clk);
		cfg_valid       = 1'b1;
		module_clock_hz = hz;
		do @(posedge clk); while (!cfg_ready);
		clock_now = hz;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// result checker and stall counter, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (done) begin
				results_seen++;
				if (pending_setups.size() == 0) begin
					flag("result with no request outstanding");
				end else begin
					oldest = pending_setups.pop_front();
					if (status !== oldest.status) begin
						flag($sformatf("status expected %0d got %0d", oldest.status, status));
					end
					if (divisor !== oldest.divisor) begin
						flag($sformatf("divisor expected %0d got %0d", oldest.divisor, divisor));
					end
					if (control_word !== oldest.ctrl) begin
						flag($sformatf("control_word expected %h got %h", oldest.ctrl,
							control_word));
					end
					if (format_word !== oldest.fmt) begin
						flag($sformatf("format_word expected %h got %h", oldest.fmt,
							format_word));
					end
					if (chip_select_used !== oldest.cs) begin
						flag($sformatf("chip_select_used expected %0d got %0d", oldest.cs,
							chip_select_used));
					end
				end
			end
		end
	end

	// nothing accepted for too long means the block is stuck
	initial begin : watchdog
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : main_seq
		arst_n          = 1'b0;
		start           = 1'b0;
		baud_rate       = '0;
		channel         = '0;
		mode            = '0;
		cfg_valid       = 1'b0;
		module_clock_hz = '0;
		clock_now       = CLK_RESET;
		blank_res       = '{ST_OK, 12'd1, CTRL_BASE, FMT_BASE, 1'b0};

		// exact hits at the reset clock, one per clock mode, bit 3 ignored
		add_fixed(CLK_RESET, 31'd40000000, CHAN_ONE, 7'(SCK_MODE0),
			ST_OK, 12'd1, CTRL_IDLE_HI, FMT_BASE, 1'b0);
		add_fixed(CLK_RESET, 31'd10000000, CHAN_TWO, 7'(SCK_MODE1),
			ST_OK, 12'd4, CTRL_IDLE_HI, FMT_PHASED, 1'b0);
		add_fixed(CLK_RESET, 31'd1000000, CHAN_FOUR, 7'(SCK_MODE2) | MODE_CS,
			ST_OK, 12'd40, CTRL_BASE, FMT_BASE, 1'b1);
		add_fixed(CLK_RESET, 31'd20000000, CHAN_ONE, 7'(SCK_MODE3) | MODE_IGNORED,
			ST_OK, 12'd2, CTRL_BASE, FMT_PHASED, 1'b0);
		// halfway between n=1 and n=2: the tie keeps the smaller divisor
		add_fixed(CLK_RESET, 31'd30000000, CHAN_TWO, 7'(SCK_MODE0),
			ST_OK, 12'd1, CTRL_IDLE_HI, FMT_BASE, 1'b0);
		// rate far above the clock: even n=1 does not improve
		add_fixed(CLK_RESET, BAUD_MAX, CHAN_FOUR, 7'(SCK_MODE0) | MODE_CS,
			ST_OK, 12'd1, CTRL_IDLE_HI, FMT_BASE, 1'b1);
		// zero rate: every divisor improves, search runs to the end
		add_fixed(CLK_RESET, 31'd0, CHAN_ONE, 7'(SCK_MODE3),
			ST_OK, 12'd4095, CTRL_BASE, FMT_PHASED, 1'b0);
		// each rejected mode bit, and mode beating a bad channel
		add_fixed(CLK_RESET, 31'd12345, CHAN_ONE, MODE_WIDE,
			ST_PROTO, 12'd1, CTRL_BASE, FMT_BASE, 1'b0);
		add_fixed(CLK_RESET, 31'd12345, CHAN_TWO, MODE_SLAVE,
			ST_PROTO, 12'd1, CTRL_BASE, FMT_BASE, 1'b0);
		add_fixed(CLK_RESET, 31'd12345, CHAN_FOUR, MODE_LINE,
			ST_PROTO, 12'd1, CTRL_BASE, FMT_BASE, 1'b0);
		add_fixed(CLK_RESET, BAUD_MAX, 4'd15, '1,
			ST_PROTO, 12'd1, CTRL_BASE, FMT_BASE, 1'b0);
		add_fixed(CLK_RESET, 31'd5000, 4'd3, MODE_REJECT,
			ST_PROTO, 12'd1, CTRL_BASE, FMT_BASE, 1'b0);
		// good mode, bad channel
		add_fixed(CLK_RESET, 31'd5000, 4'd0, 7'(SCK_MODE3) | MODE_CS | MODE_IGNORED,
			ST_CHAN, 12'd1, CTRL_BASE, FMT_BASE, 1'b0);
		add_fixed(CLK_RESET, 31'd5000, 4'd3, 7'(SCK_MODE3) | MODE_CS | MODE_IGNORED,
			ST_CHAN, 12'd1, CTRL_BASE, FMT_BASE, 1'b0);
		add_fixed(CLK_RESET, 31'd5000, 4'd8, MODE_IGNORED,
			ST_CHAN, 12'd1, CTRL_BASE, FMT_BASE, 1'b0);
		add_fixed(CLK_RESET, 31'd5000, 4'd15, 7'(SCK_MODE3) | MODE_CS,
			ST_CHAN, 12'd1, CTRL_BASE, FMT_BASE, 1'b0);
		// slowest module clock
		add_open(32'd1, 31'd0, CHAN_ONE, 7'(SCK_MODE1));
		add_open(32'd1, 31'd1, CHAN_TWO, 7'(SCK_MODE2));
		add_open(32'd1, BAUD_MAX, CHAN_FOUR, 7'(SCK_MODE3) | MODE_CS);
		// fastest module clock; its half is exactly the largest rate
		add_fixed(CLK_MAX, BAUD_MAX, CHAN_ONE, 7'(SCK_MODE0),
			ST_OK, 12'd1, CTRL_IDLE_HI, FMT_BASE, 1'b0);
		add_open(CLK_MAX, 31'd100000000, CHAN_TWO, 7'(SCK_MODE2) | MODE_CS | MODE_IGNORED);
		add_open(CLK_MAX, 31'd1073741823, CHAN_FOUR, 7'(SCK_MODE1));
		add_open(CLK_MAX, 31'h40000000, CHAN_ONE, 7'(SCK_MODE2));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].hz != clock_now) begin
				program_clock(plan[i].hz);
			end
			send_setup(plan[i].req, plan[i].typed, plan[i].res);
			hold_off($urandom_range(0, 3));
		end

		// random part under four module clock settings
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: phase_hz = $urandom_range(1000000, CLK_MAX);
				1: phase_hz = $urandom_range(1, 2000);
				2: phase_hz = CLK_RESET;
				default: phase_hz = $urandom;
			endcase
			if (phase_hz == '0) begin
				phase_hz = 32'd1;
			end
			program_clock(phase_hz);
			items_left = ITEMS_PER_CLK;
			while (items_left > 0) begin
				burst = $urandom_range(1, 8);
				while (burst > 0 && items_left > 0) begin
					send_setup(random_setup(clock_now), 1'b0, blank_res);
					burst--;
					items_left--;
				end
				// gaps short and long so they land anywhere in a search
				case ($urandom_range(0, 9)) inside
					0: drain();
					[1:3]: ;
					[4:7]: hold_off($urandom_range(1, 8));
					default: hold_off($urandom_range(9, 600));
				endcase
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (fault_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
rtl/sbds_pkg.sv
rtl/sbds_ctrl.sv
rtl/sbds_dp.sv
rtl/spi_baud_divider_search.sv
verif/spi_baud_divider_search_test.sv
